// ===== rtl/tvdlfr_pkg.sv =====
// shared types, codes and constants of the tvd face reconstruction block
`default_nettype none
package tvdlfr_pkg;

  localparam int FRAC_BITS_DEF = 16;
  // quotient bits kept by the divider (bits 32 down to 0)
  localparam int QBITS = 33;

  localparam logic [1:0] MODE_PCONST = 2'd0;
  localparam logic [1:0] MODE_MINMOD = 2'd1;
  localparam logic [1:0] MODE_MC     = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic [0:0] REG_LIMITER = 1'd0;
  localparam logic [0:0] REG_RATIO   = 1'd1;

  // item inside the divider stages, lanes 0 left, 1 centre, 2 right
  typedef struct packed {
    logic [1:0]            lmode;
    logic                  rmode;
    logic [2:0][31:0]      val;
    logic [2:0]            neg;
    logic [2:0]            ovf;
    logic [2:0]            nzero;
    logic [2:0][30:0]      nrm;
    logic [2:0][31:0]      rem;
    logic [2:0][32:0]      quo;
    logic [2:0][32:0]      dlo;
    logic [31:0]           ms;
    logic [31:0]           ps;
  } div_t;

  typedef struct packed {
    logic [1:0]  lmode;
    logic        rmode;
    logic        zero;
    logic        sat;
    logic [31:0] l;
    logic [31:0] c;
    logic [31:0] r;
    logic [31:0] ms;
    logic [31:0] ps;
  } lim_t;

  typedef struct packed {
    logic        rmode;
    logic        zero;
    logic        sat;
    logic [31:0] c;
    logic [34:0] half;
    logic [31:0] ms;
    logic [31:0] ps;
  } slp_t;

  typedef struct packed {
    logic        rmode;
    logic        zero;
    logic        sat;
    logic [31:0] fm;
    logic [31:0] fp;
    logic [31:0] ms;
    logic [31:0] ps;
  } fac_t;

  typedef struct packed {
    logic        rmode;
    logic        zero;
    logic        sat;
    logic [31:0] fm;
    logic [31:0] fp;
    logic [63:0] pm;
    logic [63:0] pp;
  } mul_t;

endpackage
`default_nettype wire

// ===== rtl/tvd_limited_face_reconstruction.sv =====
// top level: muscl face reconstruction with minmod / mc limiter or piecewise constant, q-format saturating
`default_nettype none
// One face pair per input transfer: the block takes left, centre and right values (and in
// ratio mode their norms and the two face scales), limits the slope and returns
// centre -/+ half slope with a status code; in ratio mode the values are first divided by
// their norms and the faces are multiplied by the face scales. It is a fully pipelined
// datapath: one item enters every clock while in_stall is low. Most of the pipeline is the
// ratio divider, which resolves one quotient bit per stage over 33 stages for all three lanes
// at once, after a setup stage and followed by the quotient, limiter, face, multiply and
// output stages. Every stage carries its own valid bit and advances when the stage behind it
// is empty or moving, so bubbles are squeezed out and a stalled output only holds up items
// once the pipeline is full. The limiter and ratio mode registers are sampled with each item on entry.
module tvd_limited_face_reconstruction
  import tvdlfr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [1:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_left_value,
  input  wire logic [31:0] in_centre_value,
  input  wire logic [31:0] in_right_value,
  input  wire logic [30:0] in_left_norm,
  input  wire logic [30:0] in_centre_norm,
  input  wire logic [30:0] in_right_norm,
  input  wire logic [31:0] in_minus_scale,
  input  wire logic [31:0] in_plus_scale,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_minus_face,
  output logic [31:0]      out_plus_face,
  output logic [1:0]       out_status
);

  localparam int NDIV = QBITS;
  localparam int DW   = 32 + FRAC_BITS;

  // saturate a wide signed value to 32 bits
  function automatic logic [32:0] sat36(logic signed [35:0] x);
    logic [32:0] res;
    if (x > 36'sd2147483647)       res = {1'b1, 32'h7fffffff};
    else if (x < -36'sd2147483648) res = {1'b1, 32'h80000000};
    else                           res = {1'b0, x[31:0]};
    return res;
  endfunction

  function automatic logic signed [34:0] mm2(logic signed [34:0] a, logic signed [34:0] b);
    logic signed [34:0] res;
    if (a < 0 && b < 0)      res = (a > b) ? a : b;
    else if (a > 0 && b > 0) res = (a < b) ? a : b;
    else                     res = '0;
    return res;
  endfunction

  function automatic logic signed [34:0] mm3(logic signed [34:0] a, logic signed [34:0] b,
                                             logic signed [34:0] c);
    logic signed [34:0] res;
    if ((a < 0 && b < 0 && c < 0) || (a > 0 && b > 0 && c > 0)) res = mm2(mm2(a, b), c);
    else res = '0;
    return res;
  endfunction

  // one restoring division step on all three lanes
  function automatic div_t div_step(div_t x);
    div_t       y;
    logic [32:0] t;
    logic        qb;
    y = x;
    for (int i = 0; i < 3; i++) begin
      t  = {x.rem[i], x.dlo[i][32]};
      qb = (t >= {2'b00, x.nrm[i]});
      y.rem[i] = qb ? 32'(t - {2'b00, x.nrm[i]}) : t[31:0];
      y.quo[i] = {x.quo[i][31:0], qb};
      y.dlo[i] = {x.dlo[i][31:0], 1'b0};
    end
    return y;
  endfunction

  // configuration registers
  logic [1:0] limiter_r;
  logic       ratio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limiter_r <= MODE_MINMOD;
      ratio_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LIMITER: limiter_r <= cfg_wdata;
        REG_RATIO:   ratio_r   <= cfg_wdata[0];
        default:     ;
      endcase
    end
  end

  // stage valids and ready chain; stage 0 is setup, 1..NDIV are divider steps
  logic [NDIV:0] dv_r;
  logic [NDIV:0] dr;
  div_t          st_r   [NDIV+1];
  div_t          st_nxt [NDIV+1];
  logic          vq_r, vl_r, vf_r, vm_r, vo_r;
  logic          rq, rl, rf, rm, ro;
  lim_t          q_r,  q_nxt;
  slp_t          l_r,  l_nxt;
  fac_t          f_r,  f_nxt;
  mul_t          m_r,  m_nxt;
  logic [31:0]   ofm_r, ofp_r, ofm_nxt, ofp_nxt;
  logic [1:0]    ost_r, ost_nxt;

  assign ro = !vo_r || !out_stall;
  assign rm = !vm_r || ro;
  assign rf = !vf_r || rm;
  assign rl = !vl_r || rf;
  assign rq = !vq_r || rl;
  assign dr[NDIV] = !dv_r[NDIV] || rq;

  for (genvar k = 0; k < NDIV; k++) begin : g_rdy
    assign dr[k] = !dv_r[k] || dr[k+1];
  end

  assign in_stall = !dr[0];

  // setup: magnitudes, signs, overflow pre-check and first partial remainder
  always_comb begin
    logic [2:0][31:0] vin;
    logic [2:0][30:0] nin;
    logic [31:0]      mag;
    logic [DW-1:0]    dd;
    vin = {in_right_value, in_centre_value, in_left_value};
    nin = {in_right_norm, in_centre_norm, in_left_norm};
    st_nxt[0]       = '0;
    st_nxt[0].lmode = limiter_r;
    st_nxt[0].rmode = ratio_r;
    st_nxt[0].ms    = in_minus_scale;
    st_nxt[0].ps    = in_plus_scale;
    for (int i = 0; i < 3; i++) begin
      mag = vin[i][31] ? 32'(-vin[i]) : vin[i];
      dd  = {mag, {FRAC_BITS{1'b0}}};
      st_nxt[0].val[i]   = vin[i];
      st_nxt[0].neg[i]   = vin[i][31];
      st_nxt[0].nrm[i]   = nin[i];
      st_nxt[0].nzero[i] = (nin[i] == '0);
      // quotient would need bits above bit 32
      st_nxt[0].ovf[i]   = (32'(dd >> NDIV) >= {1'b0, nin[i]});
      st_nxt[0].rem[i]   = 32'(dd >> NDIV);
      st_nxt[0].dlo[i]   = dd[NDIV-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)     dv_r[0] <= 1'b0;
    else if (dr[0]) dv_r[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (dr[0] && in_valid) st_r[0] <= st_nxt[0];
  end

  for (genvar k = 1; k <= NDIV; k++) begin : g_div
    assign st_nxt[k] = div_step(st_r[k-1]);

    always_ff @(posedge clk) begin
      if (!rst_n)     dv_r[k] <= 1'b0;
      else if (dr[k]) dv_r[k] <= dv_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (dr[k] && dv_r[k-1]) st_r[k] <= st_nxt[k];
    end
  end

  // quotient stage: sign, saturation, zero norm, or the raw values outside ratio mode
  always_comb begin
    div_t             d;
    logic [2:0][31:0] qv;
    logic [32:0]      q;
    logic             zf, sf;
    d  = st_r[NDIV];
    zf = 1'b0;
    sf = 1'b0;
    for (int i = 0; i < 3; i++) begin
      q = d.quo[i];
      if (!d.rmode) begin
        qv[i] = d.val[i];
      end else if (d.nzero[i]) begin
        qv[i] = '0;
        zf    = 1'b1;
      end else if (d.neg[i]) begin
        if (d.ovf[i] || q > 33'h080000000) begin
          qv[i] = 32'h80000000;
          sf    = 1'b1;
        end else begin
          qv[i] = 32'(-q);
        end
      end else begin
        if (d.ovf[i] || q > 33'h07fffffff) begin
          qv[i] = 32'h7fffffff;
          sf    = 1'b1;
        end else begin
          qv[i] = q[31:0];
        end
      end
    end
    q_nxt.lmode = d.lmode;
    q_nxt.rmode = d.rmode;
    q_nxt.zero  = zf;
    q_nxt.sat   = sf;
    q_nxt.l     = qv[0];
    q_nxt.c     = qv[1];
    q_nxt.r     = qv[2];
    q_nxt.ms    = d.ms;
    q_nxt.ps    = d.ps;
  end

  // limiter stage
  always_comb begin
    logic signed [34:0] sl, sc, sr, d1, d2, dc, slope;
    sl = 35'($signed(q_r.l));
    sc = 35'($signed(q_r.c));
    sr = 35'($signed(q_r.r));
    d1 = sc - sl;
    d2 = sr - sc;
    dc = (sr - sl) >>> 1;
    case (q_r.lmode)
      MODE_MINMOD: slope = mm2(d1, d2);
      MODE_MC:     slope = mm3(d1 <<< 1, d2 <<< 1, dc);
      default:     slope = '0;
    endcase
    l_nxt.rmode = q_r.rmode;
    l_nxt.zero  = q_r.zero;
    l_nxt.sat   = q_r.sat;
    l_nxt.c     = q_r.c;
    l_nxt.half  = slope >>> 1;
    l_nxt.ms    = q_r.ms;
    l_nxt.ps    = q_r.ps;
  end

  // face stage
  always_comb begin
    logic signed [35:0] c36, h36;
    logic [32:0]        sm, sp;
    c36 = 36'($signed(l_r.c));
    h36 = 36'($signed(l_r.half));
    sm  = sat36(c36 - h36);
    sp  = sat36(c36 + h36);
    f_nxt.rmode = l_r.rmode;
    f_nxt.zero  = l_r.zero;
    f_nxt.sat   = l_r.sat | sm[32] | sp[32];
    f_nxt.fm    = sm[31:0];
    f_nxt.fp    = sp[31:0];
    f_nxt.ms    = l_r.ms;
    f_nxt.ps    = l_r.ps;
  end

  // scale multiply stage
  always_comb begin
    m_nxt.rmode = f_r.rmode;
    m_nxt.zero  = f_r.zero;
    m_nxt.sat   = f_r.sat;
    m_nxt.fm    = f_r.fm;
    m_nxt.fp    = f_r.fp;
    m_nxt.pm    = 64'($signed(f_r.fm)) * 64'($signed(f_r.ms));
    m_nxt.pp    = 64'($signed(f_r.fp)) * 64'($signed(f_r.ps));
  end

  // output stage: rescale, saturate, status
  always_comb begin
    logic signed [63:0] shm, shp;
    logic [32:0]        sm, sp;
    logic               sf;
    shm = $signed(m_r.pm) >>> FRAC_BITS;
    shp = $signed(m_r.pp) >>> FRAC_BITS;
    sm  = sat36(36'(shm));
    sp  = sat36(36'(shp));
    // beyond 36 bits sat36 would miss the overflow, so test the dropped bits too
    if (shm > 64'sd2147483647)       sm = {1'b1, 32'h7fffffff};
    else if (shm < -64'sd2147483648) sm = {1'b1, 32'h80000000};
    if (shp > 64'sd2147483647)       sp = {1'b1, 32'h7fffffff};
    else if (shp < -64'sd2147483648) sp = {1'b1, 32'h80000000};
    if (m_r.rmode) begin
      ofm_nxt = sm[31:0];
      ofp_nxt = sp[31:0];
      sf      = m_r.sat | sm[32] | sp[32];
    end else begin
      ofm_nxt = m_r.fm;
      ofp_nxt = m_r.fp;
      sf      = m_r.sat;
    end
    ost_nxt = m_r.zero ? ST_DIV0 : (sf ? ST_SAT : ST_OK);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r <= 1'b0;
      vl_r <= 1'b0;
      vf_r <= 1'b0;
      vm_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rq) vq_r <= dv_r[NDIV];
      if (rl) vl_r <= vq_r;
      if (rf) vf_r <= vl_r;
      if (rm) vm_r <= vf_r;
      if (ro) vo_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rq && dv_r[NDIV]) q_r <= q_nxt;
    if (rl && vq_r)       l_r <= l_nxt;
    if (rf && vl_r)       f_r <= f_nxt;
    if (rm && vf_r)       m_r <= m_nxt;
    if (ro && vm_r) begin
      ofm_r <= ofm_nxt;
      ofp_r <= ofp_nxt;
      ost_r <= ost_nxt;
    end
  end

  assign out_valid      = vo_r;
  assign out_minus_face = ofm_r;
  assign out_plus_face  = ofp_r;
  assign out_status     = ost_r;

endmodule
`default_nettype wire

// ===== rtl/tvdlfr_chk.sv =====
// port-level checker of the tvd face reconstruction block and its bind
`default_nettype none
module tvdlfr_chk
  import tvdlfr_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_minus_face,
  input wire logic [31:0] out_plus_face,
  input wire logic [1:0]  out_status
);

  // no status code outside the defined three
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_DIV0 || out_status == ST_SAT))
    else $error("undefined status code");

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_minus_face)
      && $stable(out_plus_face) && $stable(out_status))
    else $error("stalled result changed");

  // an empty output stage frees the whole pipeline
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result after reset");

endmodule

bind tvd_limited_face_reconstruction tvdlfr_chk u_tvdlfr_chk (.*);
`default_nettype wire
